// File: rtl/apu_pkg.sv
// Shared types, constants and pipeline step functions for the Adam parameter update unit.
// No dependencies; used by adam_parameter_update_unit.
`default_nettype none

package apu_pkg;

	localparam int ELEMENTS = 4096;
	localparam int ELEM_AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
	localparam int PADDR_W = 4;

	localparam logic [24:0] ONE_Q24 = 25'd16777216;

	localparam logic [23:0] BETA1_RST = 24'd15099494;
	localparam logic [23:0] BETA2_RST = 24'd16760438;
	localparam logic [23:0] LR_RST = 24'd167772;
	localparam logic [15:0] EPS_RST = 16'd43;

	// iterations done per pipeline stage in the dividers and the square root
	localparam int DSTEP = 2;
	localparam int DV_N = 64 / DSTEP;
	localparam int SQ_N = 48 / DSTEP;
	localparam int ST_N = 42 / DSTEP;

	// stage numbering of the whole pipeline
	localparam int ST_S1 = 0;
	localparam int ST_S2 = 1;
	localparam int ST_DV0 = 2;
	localparam int ST_SQ0 = ST_DV0 + DV_N + 1;
	localparam int ST_PD = ST_SQ0 + SQ_N + 1;
	localparam int ST_ST0 = ST_PD + 1;
	localparam int ST_RS = ST_ST0 + ST_N + 1;
	localparam int ST_OUT = ST_RS + 1;
	localparam int LAT = ST_OUT + 1;

	typedef enum logic [1:0] {
		REG_BETA1 = 2'd0,
		REG_BETA2 = 2'd1,
		REG_LR    = 2'd2,
		REG_EPS   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]        elem_index;
		logic               new_step;
		logic signed [31:0] param_value;
		logic signed [31:0] grad_value;
	} item_t;

	typedef struct packed {
		logic [11:0]        out_index;
		logic signed [31:0] updated_param;
	} result_t;

	typedef struct packed {
		logic [11:0]        index;
		logic signed [31:0] param;
		logic               neg;
	} meta_t;

	// mhat and vhat dividers, running side by side
	typedef struct packed {
		logic [24:0] dm;
		logic [24:0] rm;
		logic [63:0] nm;
		logic [24:0] dv;
		logic [24:0] rv;
		logic [63:0] nv;
		logic        vsat;
	} dvs_t;

	typedef struct packed {
		logic [48:0] rem;
		logic [47:0] root;
		logic [63:0] rad;
		logic [55:0] phi;
		logic [47:0] plo;
	} sqs_t;

	typedef struct packed {
		logic [48:0] den;
		logic [48:0] rem;
		logic [41:0] nq;
		logic        sat;
		logic        dz;
	} sts_t;

	function automatic dvs_t dv_stage(dvs_t x);
		dvs_t        y;
		logic [25:0] tm;
		logic [25:0] tv;
		logic        gm;
		logic        gv;
		y = x;
		for (int i = 0; i < DSTEP; i++) begin
			tm = {y.rm, y.nm[63]};
			tv = {y.rv, y.nv[63]};
			gm = tm >= {1'b0, y.dm};
			gv = tv >= {1'b0, y.dv};
			y.nm = {y.nm[62:0], gm};
			y.nv = {y.nv[62:0], gv};
			y.rm = gm ? 25'(tm - {1'b0, y.dm}) : tm[24:0];
			y.rv = gv ? 25'(tv - {1'b0, y.dv}) : tv[24:0];
		end
		return y;
	endfunction

	function automatic sqs_t sq_stage(sqs_t x);
		sqs_t        y;
		logic [50:0] t;
		logic [49:0] trial;
		logic        ge;
		y = x;
		for (int i = 0; i < DSTEP; i++) begin
			t = {y.rem, y.rad[63:62]};
			trial = {y.root, 2'b01};
			ge = t >= {1'b0, trial};
			y.rem = ge ? 49'(t - {1'b0, trial}) : t[48:0];
			y.root = {y.root[46:0], ge};
			y.rad = {y.rad[61:0], 2'b00};
		end
		return y;
	endfunction

	function automatic sts_t st_stage(sts_t x);
		sts_t        y;
		logic [49:0] t;
		logic        ge;
		y = x;
		for (int i = 0; i < DSTEP; i++) begin
			t = {y.rem, y.nq[41]};
			ge = t >= {1'b0, y.den};
			y.nq = {y.nq[40:0], ge};
			y.rem = ge ? 49'(t - {1'b0, y.den}) : t[48:0];
		end
		return y;
	endfunction

endpackage

`default_nettype wire

// File: rtl/adam_parameter_update_unit.sv
// Adam parameter update unit: moment stores, bias powers, divide and root pipeline.
// Depends on apu_pkg.
`default_nettype none

// One word in and one word out per cycle while finished results are taken. The
// first and second moments sit in two 4096-entry memories with a registered read,
// read at acceptance and written back from stage 1; a back-to-back update of the
// same element is forwarded. The mhat/vhat divides, the square root and the final
// step divide run as pipelines doing two iterations per stage. After reset a
// clearing pass zeroes the moment memories, during which no word is accepted;
// register writes are taken. The whole pipeline holds while a finished result is
// not taken.
module adam_parameter_update_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [apu_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire apu_pkg::item_t               item,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output apu_pkg::result_t                  result
);

	localparam int AW = apu_pkg::ELEM_AW;
	localparam int LAT = apu_pkg::LAT;

	logic [23:0] b1_q, b2_q, lr_q;
	logic [15:0] eps_q;
	logic [24:0] pw1_q, pw2_q;
	logic [48:0] pw1_prod, pw2_prod;

	logic          clr_busy_q;
	logic [AW-1:0] clr_cnt_q;

	logic adv, accept;
	logic [LAT-1:0] vld_q;
	apu_pkg::meta_t meta_q [LAT];

	logic [31:0] fm_mem [apu_pkg::ELEMENTS];
	logic [47:0] sm_mem [apu_pkg::ELEMENTS];
	logic [31:0] fm_rd_q;
	logic [47:0] sm_rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [31:0]   fm_wd;
	logic [47:0]   sm_wd;

	logic [31:0] gmag;
	logic [63:0] gsq;
	logic signed [31:0] g_s1;
	logic [46:0]        g2_s1;

	logic               fwd;
	logic signed [31:0] m_old;
	logic [47:0]        v_old;
	logic [24:0]        nb1, nb2;
	logic signed [57:0] m_sum;
	logic [47:0]        pa, pb;
	logic [47:0]        pc;
	logic [48:0]        pd;
	logic [73:0]        v_sum;
	logic signed [31:0] m_new;
	logic [47:0]        v_new;
	logic [24:0]        c1, c2;

	logic signed [31:0] m_s2;
	logic [47:0]        v_s2;
	logic [24:0]        c1_s2, c2_s2;

	logic [31:0]     mmag;
	apu_pkg::dvs_t   dv_load;
	apu_pkg::dvs_t   dv_s [apu_pkg::DV_N+1];

	logic [55:0]     mhat;
	apu_pkg::sqs_t   sq_load;
	apu_pkg::sqs_t   sq_s [apu_pkg::SQ_N+1];

	logic [55:0] p_sd;
	logic [48:0] den_sd;

	apu_pkg::sts_t   st_load;
	apu_pkg::sts_t   st_s [apu_pkg::ST_N+1];

	logic [40:0]        step;
	apu_pkg::meta_t     mrs;
	logic signed [42:0] sum_sr;
	logic               dz_sr;
	logic signed [31:0] res_q;

	// register port
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		case (apu_pkg::reg_idx_t'(paddr[3:2]))
			apu_pkg::REG_BETA1: prdata = 32'(b1_q);
			apu_pkg::REG_BETA2: prdata = 32'(b2_q);
			apu_pkg::REG_LR:    prdata = 32'(lr_q);
			apu_pkg::REG_EPS:   prdata = 32'(eps_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_q <= apu_pkg::BETA1_RST;
			b2_q <= apu_pkg::BETA2_RST;
			lr_q <= apu_pkg::LR_RST;
			eps_q <= apu_pkg::EPS_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (apu_pkg::reg_idx_t'(paddr[3:2]))
				apu_pkg::REG_BETA1: b1_q <= pwdata[23:0];
				apu_pkg::REG_BETA2: b2_q <= pwdata[23:0];
				apu_pkg::REG_LR:    lr_q <= pwdata[23:0];
				apu_pkg::REG_EPS:   eps_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv = !vld_q[LAT-1] || result_ready;
	assign item_ready = adv && !clr_busy_q;
	assign accept = item_valid && item_ready;
	assign result_valid = vld_q[LAT-1];
	assign result = apu_pkg::result_t'{out_index: meta_q[apu_pkg::ST_OUT].index,
		updated_param: res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// bias powers
	assign pw1_prod = pw1_q * b1_q;
	assign pw2_prod = pw2_q * b2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw1_q <= apu_pkg::ONE_Q24;
			pw2_q <= apu_pkg::ONE_Q24;
		end else if (accept && item.new_step) begin
			pw1_q <= pw1_prod[48:24];
			pw2_q <= pw2_prod[48:24];
		end
	end

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= AW'(clr_cnt_q + 1'b1);
			if (clr_cnt_q == AW'(apu_pkg::ELEMENTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// moment memories
	assign mem_we = clr_busy_q || (adv && vld_q[apu_pkg::ST_S1]);
	assign mem_wa = clr_busy_q ? clr_cnt_q : meta_q[apu_pkg::ST_S1].index[AW-1:0];
	assign fm_wd = clr_busy_q ? '0 : m_new;
	assign sm_wd = clr_busy_q ? '0 : v_new;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fm_mem[mem_wa] <= fm_wd;
			sm_mem[mem_wa] <= sm_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fm_rd_q <= fm_mem[item.elem_index[AW-1:0]];
			sm_rd_q <= sm_mem[item.elem_index[AW-1:0]];
		end
	end

	// stage 1 input: gradient square
	assign gmag = item.grad_value[31] ? 32'(-item.grad_value) : item.grad_value;
	assign gsq = gmag * gmag;

	// stage 1: moment update with forwarding from stage 2
	assign fwd = vld_q[apu_pkg::ST_S2] &&
		(meta_q[apu_pkg::ST_S2].index[AW-1:0] == meta_q[apu_pkg::ST_S1].index[AW-1:0]);
	assign m_old = fwd ? m_s2 : fm_rd_q;
	assign v_old = fwd ? v_s2 : sm_rd_q;
	assign nb1 = 25'(apu_pkg::ONE_Q24 - {1'b0, b1_q});
	assign nb2 = 25'(apu_pkg::ONE_Q24 - {1'b0, b2_q});

	assign m_sum = m_old * $signed({1'b0, b1_q}) + g_s1 * $signed({1'b0, nb1});
	assign m_new = m_sum[55:24];

	assign pa = b2_q * v_old[47:24];
	assign pb = b2_q * v_old[23:0];
	assign pc = nb2 * g2_s1[46:24];
	assign pd = nb2 * g2_s1[23:0];
	assign v_sum = 74'({pa, 24'd0}) + 74'(pb) + 74'({pc, 24'd0}) + 74'(pd);
	assign v_new = v_sum[71:24];

	assign c1 = (pw1_q == apu_pkg::ONE_Q24) ? apu_pkg::ONE_Q24 : 25'(apu_pkg::ONE_Q24 - pw1_q);
	assign c2 = (pw2_q == apu_pkg::ONE_Q24) ? apu_pkg::ONE_Q24 : 25'(apu_pkg::ONE_Q24 - pw2_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q[apu_pkg::ST_S1].index <= item.elem_index;
			meta_q[apu_pkg::ST_S1].param <= item.param_value;
			meta_q[apu_pkg::ST_S1].neg <= 1'b0;
			g_s1 <= item.grad_value;
			g2_s1 <= gsq[62:16];
			m_s2 <= m_new;
			v_s2 <= v_new;
			c1_s2 <= c1;
			c2_s2 <= c2;
			meta_q[apu_pkg::ST_S2].index <= meta_q[apu_pkg::ST_S1].index;
			meta_q[apu_pkg::ST_S2].param <= meta_q[apu_pkg::ST_S1].param;
			meta_q[apu_pkg::ST_S2].neg <= m_new[31];
			for (int k = apu_pkg::ST_DV0; k < LAT; k++) begin
				meta_q[k] <= meta_q[k-1];
			end
		end
	end

	// mhat = |m| * 2^24 / c1, vhat = v * 2^24 / c2
	assign mmag = m_s2[31] ? 32'(-m_s2) : m_s2;

	always_comb begin
		dv_load.dm = c1_s2;
		dv_load.rm = '0;
		dv_load.nm = {8'd0, mmag, 24'd0};
		dv_load.dv = c2_s2;
		dv_load.rv = 25'(v_s2[47:40]);
		dv_load.nv = {v_s2[39:0], 24'd0};
		dv_load.vsat = 25'(v_s2[47:40]) >= c2_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= dv_load;
			for (int k = 0; k < apu_pkg::DV_N; k++) begin
				dv_s[k+1] <= apu_pkg::dv_stage(dv_s[k]);
			end
		end
	end

	// square root of vhat, lr * mhat alongside
	assign mhat = dv_s[apu_pkg::DV_N].nm[55:0];

	always_comb begin
		sq_load.rem = '0;
		sq_load.root = '0;
		sq_load.rad = dv_s[apu_pkg::DV_N].vsat ? '1 : dv_s[apu_pkg::DV_N].nv;
		sq_load.phi = lr_q * mhat[55:24];
		sq_load.plo = lr_q * mhat[23:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0] <= sq_load;
			for (int k = 0; k < apu_pkg::SQ_N; k++) begin
				sq_s[k+1] <= apu_pkg::sq_stage(sq_s[k]);
			end
			p_sd <= sq_s[apu_pkg::SQ_N].phi + 56'(sq_s[apu_pkg::SQ_N].plo[47:24]);
			den_sd <= 49'(sq_s[apu_pkg::SQ_N].root) + 49'(eps_q);
		end
	end

	// step = p * 2^32 / den, saturated at 2^40
	always_comb begin
		st_load.den = den_sd;
		st_load.rem = 49'(p_sd[55:10]);
		st_load.nq = {p_sd[9:0], 32'd0};
		st_load.sat = 49'(p_sd[55:9]) >= den_sd;
		st_load.dz = den_sd == '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s[0] <= st_load;
			for (int k = 0; k < apu_pkg::ST_N; k++) begin
				st_s[k+1] <= apu_pkg::st_stage(st_s[k]);
			end
		end
	end

	// apply step and saturate
	assign mrs = meta_q[apu_pkg::ST_RS - 1];
	assign step = (st_s[apu_pkg::ST_N].sat || st_s[apu_pkg::ST_N].nq > 42'h100_0000_0000) ?
		41'h100_0000_0000 : st_s[apu_pkg::ST_N].nq[40:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			dz_sr <= st_s[apu_pkg::ST_N].dz;
			if (mrs.neg) begin
				sum_sr <= 43'(mrs.param) + $signed({2'b00, step});
			end else begin
				sum_sr <= 43'(mrs.param) - $signed({2'b00, step});
			end
			if (dz_sr) begin
				res_q <= meta_q[apu_pkg::ST_RS].param;
			end else if (sum_sr > 43'sd2147483647) begin
				res_q <= 32'sh7fff_ffff;
			end else if (sum_sr < -43'sd2147483648) begin
				res_q <= 32'sh8000_0000;
			end else begin
				res_q <= sum_sr[31:0];
			end
		end
	end

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !item_ready)
		else $error("word accepted during clearing pass");

	a_powers_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(pw1_q <= apu_pkg::ONE_Q24) && (pw2_q <= apu_pkg::ONE_Q24))
		else $error("bias power above one");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> vld_q[apu_pkg::ST_S1])
		else $error("accepted word missing from first stage");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[LAT-1] && !result_ready) |=> (vld_q == $past(vld_q)))
		else $error("pipeline moved while result stalled");
`endif

endmodule

`default_nettype wire
